>>> rtl/core/fslf_pkg.sv
`default_nettype none
package fslf_pkg;

  localparam int PATTERN_MAX  = 8;
  localparam int WINDOW_DEPTH = 8;
  localparam int USED_MAX     = (PATTERN_MAX < WINDOW_DEPTH) ? PATTERN_MAX : WINDOW_DEPTH;
  localparam int LEN_W        = 4;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);

  localparam logic [7:0]  NEWLINE_BYTE = 8'd10;
  localparam logic [7:0]  NUL_BYTE     = 8'd0;
  localparam logic [31:0] COUNT_TOP    = 32'hFFFF_FFFF;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAT_LEN        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FOLD_CASE      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_SELECT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_ONLY     = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_VERDICT = 2'd0,
    KIND_TOTAL   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] line_num;
    logic        selected;
    logic [31:0] match_total;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef logic [WINDOW_DEPTH-1:0][7:0] window_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == COUNT_TOP) ? v : v + 32'd1;
  endfunction

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c inside {[8'd65:8'd90]}) ? c + 8'd32 : c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/fslf_if.sv
`default_nettype none
interface fslf_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_input;

  modport source (output valid, output text_byte, output end_of_input, input ready);
  modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

interface fslf_result_if;
  logic                valid;
  logic                ready;
  fslf_pkg::kind_t     kind;
  logic [31:0]         line_num;
  logic                selected;
  logic [31:0]         match_total;
  logic                last;

  modport source (output valid, output kind, output line_num, output selected,
                  output match_total, output last, input ready);
  modport sink   (input valid, input kind, input line_num, input selected,
                  input match_total, input last, output ready);
endinterface

interface fslf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fslf_pkg::CFG_INDEX_W-1:0] index;
  logic [63:0]                      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/fslf_window_match.sv
`default_nettype none
module fslf_window_match (
  input  wire fslf_pkg::window_t             window,
  input  wire logic [fslf_pkg::LEN_W-1:0]    fill,
  input  wire logic [fslf_pkg::LEN_W-1:0]    used,
  input  wire logic [63:0]                   pattern_bytes,
  input  wire logic                          fold_case,
  output logic                               hit
);
  import fslf_pkg::*;

  logic [WINDOW_DEPTH-1:0] char_ok;

  always_comb begin
    logic [7:0]       p;
    logic [7:0]       t;
    logic [LEN_W-1:0] pos;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      pos = used - LEN_W'(1) - LEN_W'(k);
      p = pattern_bytes[8*k +: 8];
      t = window[pos[IDX_W-1:0]];
      if (fold_case) begin
        p = lower_ascii(p);
        t = lower_ascii(t);
      end
      char_ok[k] = (LEN_W'(k) >= used) || (p == t);
    end
  end

  assign hit = (used != '0) && (fill >= used) && (&char_ok);

endmodule
`default_nettype wire

>>> rtl/core/fslf_out_queue.sv
`default_nettype none
module fslf_out_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fslf_pkg::push_t  push,
  output logic                  room,
  output logic                  head_valid,
  input  wire logic             head_ready,
  output fslf_pkg::result_t     head
);
  import fslf_pkg::*;

  result_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               pop;

  assign pop        = head_valid && head_ready;
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign room       = (count <= QCNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push.count) - QCNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/fixed_string_line_filter.sv
`default_nettype none
// fixed-string line filter
// text channel (sink): one item per byte, text_byte plus end_of_input; a newline
//   closes a line, end_of_input closes an open line and reports the total
// result channel (source): kind, line_num, selected, match_total, last;
//   a line verdict per closed line unless count_only, one total at the end,
//   one error item on a NUL byte; total and error carry last
// cfg channel (sink): index 0..4 picks pattern_bytes, pat_len, fold_case,
//   invert_select, count_only; always ready, write only while idle
// throughput: one text item per cycle while the result queue has room; every
//   pattern position of the 8-byte window is compared in the same cycle
// path: an item is registered at accept, evaluated once the result queue has
//   room, and its results are registered in the queue before they are offered
// a 4-entry result queue absorbs a stalled receiver; input is held off only
//   when fewer than two queue entries are free
// reset (rst, synchronous): clears registers, window, counters, halt and queue
// after an error or an end of input items are taken and dropped until reset
module fixed_string_line_filter (
  input  wire logic      clk,
  input  wire logic      rst,
  fslf_text_if.sink      text,
  fslf_result_if.source  result,
  fslf_cfg_if.sink       cfg
);
  import fslf_pkg::*;

  // configuration
  logic [63:0]      pattern_bytes;
  logic [LEN_W-1:0] pat_len;
  logic             fold_case;
  logic             invert_select;
  logic             count_only;

  // input stage
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_end;

  // line state
  window_t          window;
  window_t          window_next;
  logic [LEN_W-1:0] bytes_in_line;
  logic [LEN_W-1:0] bytes_in_line_next;
  logic             line_open;
  logic             line_open_next;
  logic             line_hit;
  logic             line_hit_next;
  logic [31:0]      lines_seen;
  logic [31:0]      lines_seen_next;
  logic [31:0]      selected_count;
  logic [31:0]      selected_count_next;
  logic             halted;
  logic             halted_next;

  logic             advance;
  logic             room;
  logic [LEN_W-1:0] used;
  logic             win_hit;
  logic             close_sel;
  logic [31:0]      close_lines;
  logic [31:0]      close_selected;
  push_t            push;
  result_t          head;

  assign used = (pat_len > LEN_W'(USED_MAX)) ? LEN_W'(USED_MAX) : pat_len;

  assign advance    = s_valid && room;
  assign text.ready = !s_valid || room;
  assign cfg.ready  = 1'b1;

  always_comb begin
    window_next = {window[WINDOW_DEPTH-2:0], s_byte};
    bytes_in_line_next = (bytes_in_line < LEN_W'(WINDOW_DEPTH)) ?
                         bytes_in_line + LEN_W'(1) : bytes_in_line;
  end

  fslf_window_match u_match (
    .window        (window_next),
    .fill          (bytes_in_line_next),
    .used          (used),
    .pattern_bytes (pattern_bytes),
    .fold_case     (fold_case),
    .hit           (win_hit)
  );

  assign close_sel      = (line_hit || (used == '0)) ^ invert_select;
  assign close_lines    = sat_inc(lines_seen);
  assign close_selected = close_sel ? sat_inc(selected_count) : selected_count;

  always_comb begin
    result_t verdict;
    result_t total;
    verdict = '{kind: KIND_VERDICT, line_num: close_lines, selected: close_sel,
                match_total: close_selected, last: 1'b0};
    total   = '{kind: KIND_TOTAL, line_num: lines_seen, selected: 1'b0,
                match_total: selected_count, last: 1'b1};
    push    = '{count: 2'd0, first: verdict, second: total};

    lines_seen_next     = lines_seen;
    selected_count_next = selected_count;
    line_open_next      = line_open;
    line_hit_next       = line_hit;
    halted_next         = halted;

    if (advance && !halted) begin
      if (s_end) begin
        halted_next = 1'b1;
        if (line_open) begin
          lines_seen_next     = close_lines;
          selected_count_next = close_selected;
          line_open_next      = 1'b0;
          line_hit_next       = 1'b0;
          total.line_num      = close_lines;
          total.match_total   = close_selected;
          if (count_only) begin
            push.count = 2'd1;
            push.first = total;
          end else begin
            push.count  = 2'd2;
            push.second = total;
          end
        end else begin
          push.count = 2'd1;
          push.first = total;
        end
      end else if (s_byte == NEWLINE_BYTE) begin
        lines_seen_next     = close_lines;
        selected_count_next = close_selected;
        line_open_next      = 1'b0;
        line_hit_next       = 1'b0;
        push.count          = count_only ? 2'd0 : 2'd1;
      end else if (s_byte == NUL_BYTE) begin
        halted_next = 1'b1;
        push.count  = 2'd1;
        push.first  = '{kind: KIND_ERROR, line_num: close_lines, selected: 1'b0,
                        match_total: selected_count, last: 1'b1};
      end else begin
        line_open_next = 1'b1;
        if (win_hit) begin
          line_hit_next = 1'b1;
        end
      end
    end
  end

  // window and fill only move on a plain text byte, and clear on a close
  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      bytes_in_line <= '0;
    end else if (advance && !halted) begin
      if (s_end || s_byte == NEWLINE_BYTE) begin
        window        <= '0;
        bytes_in_line <= '0;
      end else if (s_byte != NUL_BYTE) begin
        window        <= window_next;
        bytes_in_line <= bytes_in_line_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_open      <= 1'b0;
      line_hit       <= 1'b0;
      lines_seen     <= '0;
      selected_count <= '0;
      halted         <= 1'b0;
      s_valid        <= 1'b0;
    end else begin
      line_open      <= line_open_next;
      line_hit       <= line_hit_next;
      lines_seen     <= lines_seen_next;
      selected_count <= selected_count_next;
      halted         <= halted_next;
      if (text.ready) begin
        s_valid <= text.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s_byte <= text.text_byte;
      s_end  <= text.end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes <= '0;
      pat_len       <= '0;
      fold_case     <= 1'b0;
      invert_select <= 1'b0;
      count_only    <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_PATTERN_BYTES: pattern_bytes <= cfg.data;
        REG_PAT_LEN:       pat_len       <= cfg.data[LEN_W-1:0];
        REG_FOLD_CASE:     fold_case     <= cfg.data[0];
        REG_INVERT_SELECT: invert_select <= cfg.data[0];
        REG_COUNT_ONLY:    count_only    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  fslf_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (result.valid),
    .head_ready (result.ready),
    .head       (head)
  );

  assign result.kind        = head.kind;
  assign result.line_num    = head.line_num;
  assign result.selected    = head.selected;
  assign result.match_total = head.match_total;
  assign result.last        = head.last;

endmodule
`default_nettype wire

>>> rtl/core/fslf_checker.sv
`default_nettype none
module fslf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [1:0]  result_kind,
  input wire logic [31:0] line_num,
  input wire logic        selected,
  input wire logic [31:0] match_total,
  input wire logic        last
);
  import fslf_pkg::*;

  // nothing is offered in the cycle after a reset
  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result offered right after reset");

  // the final item of a run is the last one until reset
  a_nothing_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && last) |=> !result_valid)
    else $error("result after the final item");

  // a stalled result holds
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(result_kind) && $stable(line_num) &&
       $stable(match_total) && $stable(selected) && $stable(last)))
    else $error("stalled result changed");

  // selected lines never outnumber the lines counted
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (match_total <= line_num))
    else $error("match total above line count");

  // total and error items end the run and select nothing
  a_final_kinds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind != KIND_VERDICT) |-> (last && !selected))
    else $error("total or error item malformed");

endmodule

bind fixed_string_line_filter fslf_checker u_fslf_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_kind  (result.kind),
  .line_num     (result.line_num),
  .selected     (result.selected),
  .match_total  (result.match_total),
  .last         (result.last)
);
`default_nettype wire

>>> tb/tb_fixed_string_line_filter.sv
`default_nettype none
module tb_fixed_string_line_filter;
  import fslf_pkg::*;

  localparam int          STALL_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          TAIL_CYCLES   = 20;
  localparam int          PHASES        = 12;
  localparam int          PHASE_ITEMS   = 160;
  localparam logic [4:0]  ALL_REGS      = 5'b11111;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_end;
  } text_item_t;

  logic clk = 1'b0;
  logic rst;

  fslf_text_if   text_ch ();
  fslf_result_if res_ch ();
  fslf_cfg_if    cfg_ch ();

  fixed_string_line_filter dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the registers and the line state
  logic [63:0] pat_q;
  logic [3:0]  len_q;
  logic        fold_q;
  logic        invert_q;
  logic        count_only_q;
  logic [7:0]  win [WINDOW_DEPTH];
  int unsigned fill;
  logic        line_open;
  logic        line_hit;
  logic        halted;
  logic [31:0] lines_seen;
  logic [31:0] picked_count;

  result_t     reports_due [$];
  text_item_t  bytes_to_send [$];
  int unsigned loaded_count = 0;
  int unsigned taken_count  = 0;
  int unsigned fail_count   = 0;
  int unsigned idle_cycles  = 0;
  logic        text_fire    = 1'b0;
  int unsigned burst_run    = 0;
  int unsigned gap_run      = 0;
  int unsigned ready_run    = 0;
  int unsigned stall_run    = 0;

  function automatic logic [31:0] count_up(input logic [31:0] v);
    return (v == COUNT_TOP) ? v : v + 32'd1;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c inside {["A":"Z"]}) ? (c | 8'h20) : c;
  endfunction

  function automatic int unsigned used_len();
    return (len_q > USED_MAX) ? USED_MAX : len_q;
  endfunction

  function automatic logic window_hit();
    int unsigned n;
    logic [7:0]  p;
    logic [7:0]  t;
    n = used_len();
    if (n == 0 || fill < n) return 1'b0;
    for (int unsigned k = 0; k < n; k++) begin
      p = pat_q[8*k +: 8];
      t = win[n-1-k];
      if (fold_q) begin
        p = to_lower(p);
        t = to_lower(t);
      end
      if (p != t) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic result_t make_report(input kind_t kind, input logic [31:0] num,
                                          input logic sel, input logic [31:0] total,
                                          input logic last);
    result_t r;
    r.kind        = kind;
    r.line_num    = num;
    r.selected    = sel;
    r.match_total = total;
    r.last        = last;
    return r;
  endfunction

  task automatic clear_line();
    foreach (win[i]) win[i] = 8'd0;
    fill      = 0;
    line_open = 1'b0;
    line_hit  = 1'b0;
  endtask

  task automatic close_line();
    logic hit;
    logic sel;
    hit = line_hit || used_len() == 0;
    sel = invert_q ? !hit : hit;
    lines_seen = count_up(lines_seen);
    if (sel) picked_count = count_up(picked_count);
    clear_line();
    if (!count_only_q)
      reports_due.push_back(make_report(KIND_VERDICT, lines_seen, sel, picked_count, 1'b0));
  endtask

  task automatic scan_text_item(input logic [7:0] b, input logic is_end);
    if (halted) begin
    end else if (is_end) begin
      if (line_open) close_line();
      reports_due.push_back(make_report(KIND_TOTAL, lines_seen, 1'b0, picked_count, 1'b1));
      halted = 1'b1;
    end else if (b == NEWLINE_BYTE) begin
      close_line();
    end else if (b == NUL_BYTE) begin
      reports_due.push_back(make_report(KIND_ERROR, count_up(lines_seen), 1'b0,
                                        picked_count, 1'b1));
      halted = 1'b1;
    end else begin
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = b;
      if (fill < WINDOW_DEPTH) fill++;
      line_open = 1'b1;
      if (window_hit()) line_hit = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // monitor and predictor
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pat_q        = 64'd0;
      len_q        = 4'd0;
      fold_q       = 1'b0;
      invert_q     = 1'b0;
      count_only_q = 1'b0;
      clear_line();
      lines_seen   = 32'd0;
      picked_count = 32'd0;
      halted       = 1'b0;
      idle_cycles  = 0;
      text_fire   <= 1'b0;
    end else begin
      text_fire <= text_ch.valid && text_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_PATTERN_BYTES: pat_q        = cfg_ch.data;
          REG_PAT_LEN:       len_q        = cfg_ch.data[3:0];
          REG_FOLD_CASE:     fold_q       = cfg_ch.data[0];
          REG_INVERT_SELECT: invert_q     = cfg_ch.data[0];
          REG_COUNT_ONLY:    count_only_q = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (text_ch.valid && text_ch.ready) begin
        scan_text_item(text_ch.text_byte, text_ch.end_of_input);
        taken_count++;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (reports_due.size() == 0) begin
          fail_count++;
          $display("%0t: expected no item, got kind %0d line %0d total %0d", $time,
                   res_ch.kind, res_ch.line_num, res_ch.match_total);
        end else begin
          want = reports_due.pop_front();
          check_field("kind", 32'(want.kind), 32'(res_ch.kind));
          check_field("line_num", want.line_num, res_ch.line_num);
          check_field("selected", 32'(want.selected), 32'(res_ch.selected));
          check_field("match_total", want.match_total, res_ch.match_total);
          check_field("last", 32'(want.last), 32'(res_ch.last));
        end
      end
      if ((text_ch.valid && text_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // text driver, bursts with random gaps
  always @(negedge clk) begin
    text_item_t head;
    if (text_fire) head = bytes_to_send.pop_front();
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else if (!text_ch.valid || text_fire) begin
      if (gap_run > 0) begin
        gap_run--;
        text_ch.valid <= 1'b0;
      end else if (bytes_to_send.size() == 0) begin
        text_ch.valid <= 1'b0;
      end else begin
        head = bytes_to_send[0];
        text_ch.valid        <= 1'b1;
        text_ch.text_byte    <= head.data_byte;
        text_ch.end_of_input <= head.is_end;
        if (burst_run > 1) begin
          burst_run--;
        end else begin
          burst_run = $urandom_range(1, 40);
          gap_run   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // result receiver stalls
  always @(negedge clk) begin
    if (ready_run > 0) begin
      ready_run--;
      res_ch.ready <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
      res_ch.ready <= 1'b0;
    end else begin
      ready_run = $urandom_range(0, 30);
      stall_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      res_ch.ready <= 1'b1;
    end
  end

  function automatic void push_item(input logic [7:0] b, input logic is_end);
    bytes_to_send.push_back('{b, is_end});
    loaded_count++;
  endfunction

  function automatic void load_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endfunction

  function automatic logic [7:0] random_text_byte();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = "a";
      1: c = "b";
      2: c = "A";
      3: c = "B";
      4: c = 8'hFF;
      5: c = "c";
      default: begin
        do c = 8'($urandom_range(1, 255)); while (c == NEWLINE_BYTE);
      end
    endcase
    return c;
  endfunction

  // a line of random text with whole or partial copies of the pattern planted in it
  function automatic int unsigned load_line(input int unsigned len, input logic close);
    int unsigned put;
    int unsigned n;
    int unsigned upto;
    logic [7:0]  c;
    put = 0;
    n = used_len();
    while (put < len) begin
      if (n > 0 && $urandom_range(0, 4) == 0) begin
        upto = ($urandom_range(0, 1) == 1) ? n : $urandom_range(1, n);
        for (int unsigned k = 0; k < upto; k++) begin
          c = pat_q[8*k +: 8];
          if (c == NUL_BYTE || c == NEWLINE_BYTE) c = "a";
          if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 3) == 0)
            c = c ^ 8'h20;
          push_item(c, 1'b0);
        end
        put += upto;
      end else begin
        push_item(random_text_byte(), 1'b0);
        put++;
      end
    end
    if (close) push_item(NEWLINE_BYTE, 1'b0);
    return put + close;
  endfunction

  task automatic wait_quiet();
    do @(negedge clk); while (taken_count != loaded_count || reports_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_config(input logic [63:0] pat, input logic [3:0] len, input logic fold,
                            input logic inv, input logic co, input logic [4:0] mask);
    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mask[REG_PATTERN_BYTES]) write_reg(REG_PATTERN_BYTES, pat);
    if (mask[REG_PAT_LEN])       write_reg(REG_PAT_LEN, 64'(len));
    if (mask[REG_FOLD_CASE])     write_reg(REG_FOLD_CASE, 64'(fold));
    if (mask[REG_INVERT_SELECT]) write_reg(REG_INVERT_SELECT, 64'(inv));
    if (mask[REG_COUNT_ONLY])    write_reg(REG_COUNT_ONLY, 64'(co));
    @(negedge clk) cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned n;
    logic [63:0] pat;
    logic [3:0]  len;
    rst                  = 1'b1;
    text_ch.valid        = 1'b0;
    text_ch.text_byte    = 8'd0;
    text_ch.end_of_input = 1'b0;
    res_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_PATTERN_BYTES;
    cfg_ch.data          = 64'd0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // empty pattern after reset: every line is a hit, the empty line included
    load_text("\n");
    push_item(8'hFF, 1'b0);
    load_text("\n");
    // case folded hit, then a miss
    set_config(64'h6241, 4'd2, 1'b1, 1'b0, 1'b0, ALL_REGS);
    load_text("zAB\na\n");
    // exact case, inverted
    set_config(64'h6241, 4'd2, 1'b0, 1'b1, 1'b0, ALL_REGS);
    load_text("ab\n");
    // length beyond the window is cut to the window
    set_config(64'h4847_4645_4443_4241, 4'd12, 1'b0, 1'b1, 1'b0, ALL_REGS);
    load_text("ABCDEFGH\n");
    // totals only
    set_config(64'h4847_4645_4443_4241, 4'd12, 1'b0, 1'b1, 1'b1, ALL_REGS);
    load_text("x\n");

    for (int ph = 0; ph < PHASES; ph++) begin
      pat = 64'd0;
      for (int k = 0; k < 8; k++)
        pat[8*k +: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : random_text_byte();
      case (ph)
        0: begin
          pat = '1;
          len = 4'd8;
        end
        1: begin
          pat = 64'd0;
          len = 4'd15;
        end
        2: len = 4'd0;
        default: begin
          case ($urandom_range(0, 9))
            0: len = 4'($urandom_range(9, 15));
            1: len = 4'd8;
            2: len = 4'd0;
            default: len = 4'($urandom_range(1, 4));
          endcase
        end
      endcase
      set_config(pat, len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 3) == 0), (ph < 3) ? ALL_REGS : 5'($urandom_range(1, 31)));
      n = 0;
      while (n < PHASE_ITEMS)
        n += load_line(($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                   : $urandom_range(0, 10), 1'b1);
      // leave a line open across the next register change
      if ($urandom_range(0, 1) == 1) n = load_line($urandom_range(1, 6), 1'b0);
    end

    if ($urandom_range(0, 1) == 1) n = load_line($urandom_range(1, 10), 1'b0);
    if ($urandom_range(0, 1) == 1) begin
      push_item(NUL_BYTE, 1'b0);
      push_item(8'($urandom), 1'b1);
    end else begin
      push_item(8'($urandom), 1'b1);
      push_item(NUL_BYTE, 1'b0);
      push_item(NEWLINE_BYTE, 1'b0);
      push_item("a", 1'b0);
      push_item(8'($urandom), 1'b1);
    end

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

>>> fixed_string_line_filter.f
rtl/core/fslf_pkg.sv
rtl/core/fslf_if.sv
rtl/core/fslf_window_match.sv
rtl/core/fslf_out_queue.sv
rtl/core/fixed_string_line_filter.sv
rtl/core/fslf_checker.sv
tb/tb_fixed_string_line_filter.sv
